// File: sv/restart_limit_scheduler_defines.svh
// ----------------------------------------------------------------------------
// restart_limit_scheduler_defines
// assertion macros used by the restart-limit scheduler checker
// ----------------------------------------------------------------------------
`ifndef RESTART_LIMIT_SCHEDULER_DEFINES_SVH
`define RESTART_LIMIT_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define RLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg
// types and fixed constants of the restart-limit scheduler
// ----------------------------------------------------------------------------
package rls_pkg;

	localparam int LIMIT_W     = 31;
	localparam int NUM_W       = 24;
	localparam int MODE_W      = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 56;
	localparam int LUBY_K_W    = 7;

	localparam logic [LIMIT_W-1:0]  LIMIT_MAX    = 31'h7FFF_FFFF;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 31'd100;
	localparam logic [LUBY_K_W-1:0] LUBY_MUL_10  = 7'd10;
	localparam logic [LUBY_K_W-1:0] LUBY_MUL_100 = 7'd100;
	localparam logic [LUBY_K_W-1:0] LUBY_MUL_50  = 7'd50;

	typedef enum logic [MODE_W-1:0] {
		MODE_DOUBLE,
		MODE_LUBY10,
		MODE_LUBY100,
		MODE_LUBY50,
		MODE_GROW103,
		MODE_GROW110,
		MODE_GROW150
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCHEDULE_MODE,
		REG_INITIAL_LIMIT
	} reg_index_t;

endpackage

// File: sv/rls_mul.sv
// ----------------------------------------------------------------------------
// rls_mul
// shared registered multiplier for luby scaling and fixed-point growth
// ----------------------------------------------------------------------------
module rls_mul import rls_pkg::*; #(
	parameter int FAC_W = 18
) (
	input  logic                     clk,
	input  logic [LIMIT_W-1:0]       a,
	input  logic [FAC_W-1:0]         b,
	output logic [LIMIT_W+FAC_W-1:0] prod
);

	logic [LIMIT_W+FAC_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= (LIMIT_W+FAC_W)'(a) * (LIMIT_W+FAC_W)'(b);
	end

	assign prod = prod_q;

endmodule

// File: sv/rls_luby.sv
// ----------------------------------------------------------------------------
// rls_luby
// iterative luby term: one compare-and-shift or compare-and-subtract per cycle
// ----------------------------------------------------------------------------
module rls_luby import rls_pkg::*; #(
	parameter int COUNT_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [COUNT_BITS+1:0]   m_init,
	output logic                    done,
	output logic [COUNT_BITS:0]     value
);

	localparam int LW = COUNT_BITS + 2;
	localparam logic [LW-1:0] PW_INIT = LW'(1) << (COUNT_BITS + 1);
	localparam logic [LW-1:0] TWO     = LW'(2);
	localparam logic [LW-1:0] ONE     = LW'(1);

	logic [LW-1:0]         m_q;
	logic [LW-1:0]         pw_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COUNT_BITS:0]   value_q;
	logic [LW-1:0]         half;

	assign half = pw_q >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q     <= '0;
			pw_q    <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			value_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				m_q    <= m_init;
				pw_q   <= PW_INIT;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				priority if (pw_q > TWO && half >= m_q) begin
					pw_q <= half;
				end else if (pw_q == m_q) begin
					value_q <= half[COUNT_BITS:0];
					done_q  <= 1'b1;
					busy_q  <= 1'b0;
				end else begin
					m_q <= m_q - half + ONE;
				end
			end
		end
	end

	assign done  = done_q;
	assign value = value_q;

endmodule

// File: sv/restart_limit_scheduler.sv
// ----------------------------------------------------------------------------
// restart_limit_scheduler
// restart counter and conflict-limit schedule for a conflict-driven solver
// ----------------------------------------------------------------------------
// Each input word carries restart_event in bit 0 and produces one output word
// with the conflict limit, the restart count and a saturation flag. The block
// takes one word at a time. A report-only word goes straight to the finish
// state; doubling and x1.5 are computed in the start state; x1.03 and x1.1
// use the shared multiplier twice (fraction, then integer part); the Luby
// modes wait for the Luby unit, which spends one cycle per shift or subtract
// step, and then scale its term on the shared multiplier. A finished word
// waits in the output register while the next word is taken; a word that
// finds the output register still full waits until it is read.
// ----------------------------------------------------------------------------
module restart_limit_scheduler import rls_pkg::*; #(
	parameter int COUNT_BITS = 24,
	parameter int FRAC_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [LIMIT_W-1:0]     cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // restart_event, zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // conflict_limit, restart_number, zero pad
	output logic                   m_tuser    // limit_saturated
);

	localparam int FAC_W    = FRAC_BITS + 2;
	localparam int PROD_W   = LIMIT_W + FAC_W;
	localparam int SCALED_W = LIMIT_W + FRAC_BITS;
	localparam int LW       = COUNT_BITS + 2;
	localparam int EXT_W    = COUNT_BITS + NUM_W;

	localparam logic [FAC_W-1:0] GROW_LOW =
		FAC_W'((64'd103 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [FAC_W-1:0] GROW_TEN =
		FAC_W'((64'd11 * (64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_LUBY,
		ST_LUBY_SCALE,
		ST_GEO_WHOLE,
		ST_GEO_SUM,
		ST_FINISH
	} state_t;

	state_t                state_q;
	logic [MODE_W-1:0]     mode_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [LIMIT_W-1:0]    limit_q;
	logic [SCALED_W-1:0]   scaled_q;
	logic                  sat_q;
	logic [FAC_W-1:0]      frac_part_q;
	logic                  m_tvalid_q;
	logic [LIMIT_W-1:0]    out_limit_q;
	logic [NUM_W-1:0]      out_num_q;
	logic                  out_sat_q;

	logic [LIMIT_W:0]      dbl_sum;
	logic [LIMIT_W:0]      half_sum;
	logic [PROD_W:0]       geo_sum;
	logic                  geo_over;
	logic                  luby_over;
	logic [EXT_W-1:0]      count_ext;
	logic                  is_luby;
	logic                  luby_start;
	logic                  luby_done;
	logic [COUNT_BITS:0]   luby_val;
	logic [LIMIT_W-1:0]    mul_a;
	logic [FAC_W-1:0]      mul_b;
	logic [PROD_W-1:0]     prod;
	logic [FAC_W-1:0]      grow_fac;
	logic [FAC_W-1:0]      luby_fac;

	assign dbl_sum   = {1'b0, limit_q} + {1'b0, limit_q};
	assign half_sum  = {1'b0, limit_q} + {2'b0, limit_q[LIMIT_W-1:1]};
	assign geo_sum   = {1'b0, prod} + (PROD_W+1)'(frac_part_q);
	assign geo_over  = |geo_sum[PROD_W:SCALED_W];
	assign luby_over = |prod[PROD_W-1:LIMIT_W];
	assign count_ext = EXT_W'(count_q);

	assign is_luby = (mode_q == MODE_LUBY10) || (mode_q == MODE_LUBY100)
		|| (mode_q == MODE_LUBY50);
	assign luby_start = (state_q == ST_START) && is_luby;
	assign grow_fac = (mode_q == MODE_GROW103) ? GROW_LOW : GROW_TEN;

	always_comb begin
		unique case (mode_q)
			MODE_LUBY10:  luby_fac = FAC_W'(LUBY_MUL_10);
			MODE_LUBY100: luby_fac = FAC_W'(LUBY_MUL_100);
			default:      luby_fac = FAC_W'(LUBY_MUL_50);
		endcase
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_START: begin
				mul_a = LIMIT_W'(scaled_q[FRAC_BITS-1:0]);
				mul_b = grow_fac;
			end
			ST_GEO_WHOLE: begin
				mul_a = scaled_q[SCALED_W-1:FRAC_BITS];
				mul_b = grow_fac;
			end
			ST_LUBY: begin
				mul_a = LIMIT_W'(luby_val);
				mul_b = luby_fac;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	rls_luby #(
		.COUNT_BITS(COUNT_BITS)
	) u_luby (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (luby_start),
		.m_init (LW'(count_q) + LW'(2)),
		.done   (luby_done),
		.value  (luby_val)
	);

	rls_mul #(
		.FAC_W(FAC_W)
	) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_GROW150;
			count_q     <= '0;
			limit_q     <= LIMIT_RESET;
			scaled_q    <= {LIMIT_RESET, FRAC_BITS'(0)};
			sat_q       <= 1'b0;
			frac_part_q <= '0;
			m_tvalid_q  <= 1'b0;
			out_limit_q <= '0;
			out_num_q   <= '0;
			out_sat_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (reg_index_t'(cfg_index))
					REG_SCHEDULE_MODE: mode_q <= cfg_data[MODE_W-1:0];
					REG_INITIAL_LIMIT: begin
						limit_q  <= cfg_data;
						scaled_q <= {cfg_data, FRAC_BITS'(0)};
						count_q  <= '0;
					end
					default: mode_q <= mode_q;
				endcase
			end
			if (m_tvalid_q && m_tready && state_q != ST_FINISH) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						sat_q <= 1'b0;
						if (s_tdata[0]) begin
							if (count_q != COUNT_MAX) begin
								count_q <= count_q + COUNT_BITS'(1);
							end
							state_q <= ST_START;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_START: begin
					unique case (mode_q)
						MODE_DOUBLE: begin
							limit_q <= dbl_sum[LIMIT_W] ? LIMIT_MAX : dbl_sum[LIMIT_W-1:0];
							sat_q   <= dbl_sum[LIMIT_W];
							state_q <= ST_FINISH;
						end
						MODE_LUBY10, MODE_LUBY100, MODE_LUBY50: begin
							state_q <= ST_LUBY;
						end
						MODE_GROW103, MODE_GROW110: begin
							state_q <= ST_GEO_WHOLE;
						end
						default: begin
							limit_q <= half_sum[LIMIT_W] ? LIMIT_MAX : half_sum[LIMIT_W-1:0];
							sat_q   <= half_sum[LIMIT_W];
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_LUBY: begin
					if (luby_done) begin
						state_q <= ST_LUBY_SCALE;
					end
				end
				ST_LUBY_SCALE: begin
					limit_q <= luby_over ? LIMIT_MAX : prod[LIMIT_W-1:0];
					sat_q   <= luby_over;
					state_q <= ST_FINISH;
				end
				ST_GEO_WHOLE: begin
					frac_part_q <= prod[FRAC_BITS+FAC_W-1:FRAC_BITS];
					state_q     <= ST_GEO_SUM;
				end
				ST_GEO_SUM: begin
					if (geo_over) begin
						scaled_q <= '1;
						limit_q  <= LIMIT_MAX;
						sat_q    <= 1'b1;
					end else begin
						scaled_q <= geo_sum[SCALED_W-1:0];
						limit_q  <= geo_sum[SCALED_W-1:FRAC_BITS];
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						out_limit_q <= limit_q;
						out_num_q   <= count_ext[NUM_W-1:0];
						out_sat_q   <= sat_q;
						m_tvalid_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_num_q, out_limit_q};
	assign m_tuser  = out_sat_q;

endmodule

// File: sv/rls_checker.sv
// ----------------------------------------------------------------------------
// rls_checker
// port-level checks of the restart-limit scheduler
// ----------------------------------------------------------------------------
`include "restart_limit_scheduler_defines.svh"

module rls_checker import rls_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser
);

	// one word in flight: busy right after taking a word
	`RLS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "scheduler ready again right after accepting a word")

	// a clipped limit must read as the maximum
	`RLS_ASSERT_NOW(a_sat_means_max, clk, arst_n, m_tvalid && m_tuser, m_tdata[LIMIT_W-1:0] == LIMIT_MAX, "saturation flag set without a maximum limit")

	// a stalled output word holds
	`RLS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

endmodule

bind restart_limit_scheduler rls_checker u_rls_checker (.*);
